@@ rtl/core/spq_pkg.sv @@
// Shared types, codes and sizes for the sorted priority queue.
package spq_pkg;

	localparam int unsigned QUEUE_DEPTH = 16;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned KEY_W = 32;
	localparam int unsigned TAG_W = 8;
	localparam int unsigned OCC_W = 5;
	localparam int unsigned STATUS_W = 2;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} entry_t;

	typedef struct packed {
		logic ins;
		logic rem;
		logic max_first;
		logic signed [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} cmd_t;

endpackage

@@ rtl/core/spq_cell.sv @@
// One storage cell of the sorted queue: holds an entry and shifts with its neighbors.
module spq_cell (
	input  logic             clk,
	input  spq_pkg::cmd_t    cmd,
	input  logic             valid,
	input  spq_pkg::entry_t  left,
	input  spq_pkg::entry_t  right,
	input  logic             found_in,
	output logic             found_out,
	output spq_pkg::entry_t  entry_q
);

	logic ahead;
	logic place;

	always_comb begin
		if (cmd.max_first) begin
			ahead = (cmd.key >= entry_q.key);
		end else begin
			ahead = (cmd.key <= entry_q.key);
		end
		place = !valid || ahead;
		found_out = found_in || place;
	end

	// An insert shifts away from the head past the insertion point, a remove toward it.
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (found_in) begin
				entry_q <= left;
			end else if (place) begin
				entry_q.key <= cmd.key;
				entry_q.tag <= cmd.tag;
			end
		end else if (cmd.rem) begin
			entry_q <= right;
		end
	end

endmodule

@@ rtl/core/sorted_priority_queue.sv @@
// Top level of the sorted priority queue: a row of cells, the entry count and the result register.
// The queue holds up to QUEUE_DEPTH entries sorted so that cell 0 is the head, and takes one
// insert or remove beat per cycle unless a held result stalls it; its result appears on the master
// side in the cycle after the beat is accepted, and a new beat is taken while the previous result is
// being taken. Every cell compares the new key with its own in parallel, and the insertion point is
// found by a flag that ripples through the row of cells, which sets the length of the cycle.
module sorted_priority_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,    // order_max_first
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,     // key[31:0], tag[39:32]
	input  logic        s_tuser,     // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,     // out_key[31:0], out_tag[39:32], occupancy[44:40], zero
	output logic [1:0]  m_tuser      // status
);

	logic order_q;
	logic [spq_pkg::CNT_W-1:0] cnt_q;
	logic m_valid_q;
	logic signed [spq_pkg::KEY_W-1:0] out_key_q;
	logic [spq_pkg::TAG_W-1:0] out_tag_q;
	logic [spq_pkg::STATUS_W-1:0] status_q;

	logic accept;
	logic full;
	logic empty;
	spq_pkg::cmd_t cmd;
	spq_pkg::entry_t ent [spq_pkg::QUEUE_DEPTH];
	logic [spq_pkg::QUEUE_DEPTH:0] found;
	spq_pkg::entry_t new_entry;

	assign cfg_ready = 1'b1;
	assign s_tready = !m_valid_q || m_tready;
	assign accept = s_tvalid && s_tready;
	assign full = (cnt_q == spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH));
	assign empty = (cnt_q == '0);

	always_comb begin
		cmd.ins = accept && (s_tuser == spq_pkg::OP_INSERT) && !full;
		cmd.rem = accept && (s_tuser == spq_pkg::OP_REMOVE) && !empty;
		cmd.max_first = order_q;
		cmd.key = s_tdata[31:0];
		cmd.tag = s_tdata[39:32];
		new_entry.key = s_tdata[31:0];
		new_entry.tag = s_tdata[39:32];
	end

	assign found[0] = 1'b0;

	for (genvar i = 0; i < spq_pkg::QUEUE_DEPTH; i++) begin : g_cell
		spq_pkg::entry_t left_e;
		spq_pkg::entry_t right_e;
		if (i == 0) begin : g_first
			assign left_e = new_entry;
		end else begin : g_mid_l
			assign left_e = ent[i-1];
		end
		if (i == spq_pkg::QUEUE_DEPTH - 1) begin : g_last
			assign right_e = '0;
		end else begin : g_mid_r
			assign right_e = ent[i+1];
		end
		spq_cell u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.valid     (cnt_q > spq_pkg::CNT_W'(i)),
			.left      (left_e),
			.right     (right_e),
			.found_in  (found[i]),
			.found_out (found[i+1]),
			.entry_q   (ent[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 1'b0;
			cnt_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				order_q <= cfg_data;
			end
			if (cmd.ins) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.rem) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (accept) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_key_q <= '0;
			out_tag_q <= '0;
			status_q <= spq_pkg::ST_OK;
			if (s_tuser == spq_pkg::OP_REMOVE) begin
				if (empty) begin
					status_q <= spq_pkg::ST_EMPTY;
				end else begin
					out_key_q <= ent[0].key;
					out_tag_q <= ent[0].tag;
				end
			end else if (full) begin
				status_q <= spq_pkg::ST_FULL;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {3'b000, spq_pkg::OCC_W'(cnt_q), out_tag_q, out_key_q};
	assign m_tuser = status_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH))
		else $error("entry count beyond queue depth");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == spq_pkg::OP_REMOVE && empty)
		|=> (m_tvalid && m_tuser == spq_pkg::ST_EMPTY))
		else $error("remove on empty queue not flagged");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == spq_pkg::OP_INSERT && !full)
		|=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("insert did not advance the entry count");

	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == spq_pkg::OP_INSERT && full)
		|=> ($stable(cnt_q) && m_tuser == spq_pkg::ST_FULL))
		else $error("insert on full queue changed the queue");
`endif

endmodule

@@ bench/sorted_priority_queue_tb.sv @@
// Self-checking testbench for the sorted priority queue: stream driver, monitor and predictor.
module sorted_priority_queue_tb;

	typedef enum logic [1:0] {
		K_BEAT,
		K_ORDER,
		K_DRAIN
	} backlog_kind_t;

	typedef struct {
		backlog_kind_t kind;
		logic mode;
		logic signed [spq_pkg::KEY_W-1:0] key;
		logic [spq_pkg::TAG_W-1:0] tag;
		logic order;
	} backlog_t;

	typedef struct {
		logic signed [spq_pkg::KEY_W-1:0] key;
		logic [spq_pkg::TAG_W-1:0] tag;
		logic [spq_pkg::STATUS_W-1:0] status;
		logic [spq_pkg::OCC_W-1:0] occ;
	} queue_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [39:0] s_tdata = '0;      // key[31:0], tag[39:32]
	logic s_tuser = 1'b0;           // mode
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [47:0] m_tdata;           // out_key[31:0], out_tag[39:32], occupancy[44:40], zero
	logic [1:0] m_tuser;            // status

	sorted_priority_queue u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	backlog_t pending_ops[$];
	queue_result_t predicted_results[$];

	logic signed [spq_pkg::KEY_W-1:0] held_key[spq_pkg::QUEUE_DEPTH];
	logic [spq_pkg::TAG_W-1:0] held_tag[spq_pkg::QUEUE_DEPTH];
	int held_count = 0;
	logic order_max_first_model = 1'b0;

	logic s_taken = 1'b0;
	logic cfg_taken = 1'b0;
	int beats_sent = 0;
	int results_seen = 0;
	int errors = 0;
	int inserts_done = 0;
	int removes_done = 0;
	int full_drops = 0;
	int empty_removes = 0;
	int order_writes = 0;
	int hold_left = 0;
	int next_hold_at = 300;
	logic calm;

	assign calm = (beats_sent >= 400) && (beats_sent < 560);

	always #5 clk = ~clk;

	function automatic queue_result_t compute_queue_op(logic mode,
			logic signed [spq_pkg::KEY_W-1:0] key, logic [spq_pkg::TAG_W-1:0] tag);
		queue_result_t r;
		int pos;
		int i;
		r.key = '0;
		r.tag = '0;
		r.status = spq_pkg::ST_OK;
		if (mode == spq_pkg::OP_INSERT) begin
			if (held_count >= spq_pkg::QUEUE_DEPTH) begin
				r.status = spq_pkg::ST_FULL;
				full_drops++;
			end else begin
				pos = 0;
				while (pos < held_count && !(order_max_first_model ? key >= held_key[pos]
						: key <= held_key[pos]))
					pos++;
				for (i = held_count; i > pos; i--) begin
					held_key[i] = held_key[i-1];
					held_tag[i] = held_tag[i-1];
				end
				held_key[pos] = key;
				held_tag[pos] = tag;
				held_count++;
				inserts_done++;
			end
		end else begin
			if (held_count == 0) begin
				r.status = spq_pkg::ST_EMPTY;
				empty_removes++;
			end else begin
				r.key = held_key[0];
				r.tag = held_tag[0];
				for (i = 1; i < held_count; i++) begin
					held_key[i-1] = held_key[i];
					held_tag[i-1] = held_tag[i];
				end
				held_count--;
				removes_done++;
			end
		end
		r.occ = spq_pkg::OCC_W'(held_count);
		return r;
	endfunction

	// Monitor: configuration tracking, result checking and prediction on accepted beats.
	always @(posedge clk) begin
		queue_result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				order_max_first_model = cfg_data;
				order_writes++;
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (predicted_results.size() == 0) begin
					$display("%0t: unexpected result beat %h status %h", $time, m_tdata, m_tuser);
					errors++;
				end else begin
					want = predicted_results.pop_front();
					if (m_tdata[31:0] !== want.key) begin
						$display("%0t: out_key expected %h actual %h", $time, want.key,
							m_tdata[31:0]);
						errors++;
					end
					if (m_tdata[39:32] !== want.tag) begin
						$display("%0t: out_tag expected %h actual %h", $time, want.tag,
							m_tdata[39:32]);
						errors++;
					end
					if (m_tdata[44:40] !== want.occ) begin
						$display("%0t: occupancy expected %0d actual %0d", $time, want.occ,
							m_tdata[44:40]);
						errors++;
					end
					if (m_tuser !== want.status) begin
						$display("%0t: status expected %0d actual %0d", $time, want.status,
							m_tuser);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready)
				predicted_results.push_back(compute_queue_op(s_tuser, s_tdata[31:0],
					s_tdata[39:32]));
		end
		s_taken <= arst_n && s_tvalid && s_tready;
		cfg_taken <= arst_n && cfg_valid && cfg_ready;
	end

	// Driver: feeds beats, order writes and drain pauses from the backlog.
	always @(negedge clk) begin
		backlog_t head;
		logic nv;
		logic [39:0] nd;
		logic nu;
		logic ncv;
		logic ncd;
		nv = s_tvalid;
		nd = s_tdata;
		nu = s_tuser;
		ncv = cfg_valid;
		ncd = cfg_data;
		if (arst_n) begin
			if (cfg_valid && cfg_taken)
				ncv = 1'b0;
			if (!(s_tvalid && !s_taken) && !(cfg_valid && !cfg_taken)) begin
				nv = 1'b0;
				if (pending_ops.size() != 0) begin
					head = pending_ops[0];
					case (head.kind)
						K_BEAT: begin
							if (calm || $urandom_range(99) >= 32) begin
								void'(pending_ops.pop_front());
								nv = 1'b1;
								nd = {head.tag, head.key};
								nu = head.mode;
								beats_sent++;
							end
						end
						K_ORDER: begin
							if (predicted_results.size() == 0 && !ncv) begin
								void'(pending_ops.pop_front());
								ncv = 1'b1;
								ncd = head.order;
							end
						end
						default: begin
							if (predicted_results.size() == 0)
								void'(pending_ops.pop_front());
						end
					endcase
				end
			end
		end
		s_tvalid <= nv;
		s_tdata <= nd;
		s_tuser <= nu;
		cfg_valid <= ncv;
		cfg_data <= ncd;
	end

	// Receiver: random stalls plus long hold-offs that back the queue up.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (results_seen >= next_hold_at) begin
			hold_left <= 80;
			next_hold_at <= next_hold_at + 450;
			m_tready <= 1'b0;
		end else begin
			m_tready <= calm || $urandom_range(99) >= 32;
		end
	end

	function automatic void add_beat(logic mode, logic signed [spq_pkg::KEY_W-1:0] key,
			logic [spq_pkg::TAG_W-1:0] tag);
		backlog_t b;
		b.kind = K_BEAT;
		b.mode = mode;
		b.key = key;
		b.tag = tag;
		b.order = 1'b0;
		pending_ops.push_back(b);
	endfunction

	function automatic void add_marker(backlog_kind_t kind, logic order);
		backlog_t b;
		b.kind = kind;
		b.mode = spq_pkg::OP_INSERT;
		b.key = '0;
		b.tag = '0;
		b.order = order;
		pending_ops.push_back(b);
	endfunction

	function automatic logic [spq_pkg::TAG_W-1:0] pick_tag();
		return spq_pkg::TAG_W'($urandom);
	endfunction

	function automatic logic signed [spq_pkg::KEY_W-1:0] pick_key();
		logic signed [spq_pkg::KEY_W-1:0] k;
		case ($urandom_range(7))
			0: begin
				case ($urandom_range(3))
					0: k = 32'h7FFF_FFFF;
					1: k = 32'h8000_0000;
					2: k = 32'h0;
					default: k = 32'hFFFF_FFFF;
				endcase
			end
			1, 2: k = int'($urandom_range(8)) - 4;
			default: k = $urandom;
		endcase
		return k;
	endfunction

	initial begin
		logic order_plan[8];
		int insert_bias[8];
		int p;
		int i;
		order_plan = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
		insert_bias = '{50, 70, 30, 55, 80, 20, 50, 60};

		// Smallest-first fill to the limit, with extremes and runs of equal keys.
		add_beat(spq_pkg::OP_REMOVE, $urandom, pick_tag());
		add_beat(spq_pkg::OP_INSERT, 32'h7FFF_FFFF, 8'hFF);
		add_beat(spq_pkg::OP_INSERT, 32'h8000_0000, 8'h00);
		add_beat(spq_pkg::OP_INSERT, 32'h0, 8'h01);
		add_beat(spq_pkg::OP_INSERT, -1, 8'h02);
		add_beat(spq_pkg::OP_INSERT, 1, 8'h03);
		add_beat(spq_pkg::OP_INSERT, 5, 8'h10);
		add_beat(spq_pkg::OP_INSERT, 5, 8'h11);
		add_beat(spq_pkg::OP_INSERT, 5, 8'h12);
		add_beat(spq_pkg::OP_INSERT, 32'h8000_0000, 8'h13);
		add_beat(spq_pkg::OP_INSERT, 32'h7FFF_FFFF, 8'h14);
		add_beat(spq_pkg::OP_INSERT, 100, 8'h15);
		add_beat(spq_pkg::OP_INSERT, -100, 8'h16);
		add_beat(spq_pkg::OP_INSERT, 2, 8'h17);
		add_beat(spq_pkg::OP_INSERT, -2, 8'h18);
		add_beat(spq_pkg::OP_INSERT, 3, 8'h19);
		add_beat(spq_pkg::OP_INSERT, 4, 8'h1A);
		add_beat(spq_pkg::OP_INSERT, 0, 8'hEE);
		// Switch to largest-first with the queue still holding entries.
		add_marker(K_ORDER, 1'b1);
		add_beat(spq_pkg::OP_REMOVE, $urandom, pick_tag());
		add_beat(spq_pkg::OP_REMOVE, $urandom, pick_tag());
		add_beat(spq_pkg::OP_INSERT, 5, 8'h20);
		add_beat(spq_pkg::OP_INSERT, -5, 8'h21);
		add_beat(spq_pkg::OP_REMOVE, $urandom, pick_tag());
		add_beat(spq_pkg::OP_REMOVE, $urandom, pick_tag());
		add_marker(K_DRAIN, 1'b0);

		for (p = 0; p < 8; p++) begin
			add_marker(K_ORDER, order_plan[p]);
			for (i = 0; i < 135; i++) begin
				if (i == 60)
					add_marker(K_DRAIN, 1'b0);
				add_beat(($urandom_range(99) < insert_bias[p]) ? spq_pkg::OP_INSERT
					: spq_pkg::OP_REMOVE, pick_key(), pick_tag());
			end
		end

		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		while (pending_ops.size() != 0 || s_tvalid || cfg_valid || predicted_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Covered %0d beats: %0d inserts, %0d removes, %0d full drops, %0d empty removes.",
			beats_sent, inserts_done, removes_done, full_drops, empty_removes);
		$display("Order register written %0d times across both orders; %0d result beats checked.",
			order_writes, results_seen);
		if (errors == 0 && predicted_results.size() == 0) begin
			$display("sorted_priority_queue_tb: PASS");
		end else begin
			$display("sorted_priority_queue_tb: FAIL");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("sorted_priority_queue_tb: FAIL");
		$finish;
	end

endmodule
